>>> sv/timed_valve_command_controller_defines.svh
// Assertion macros for the timed valve command controller.
`ifndef TIMED_VALVE_COMMAND_CONTROLLER_DEFINES_SVH
`define TIMED_VALVE_COMMAND_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define TVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tvc_pkg.sv
// Types and codes shared by the timed valve command controller.
package tvc_pkg;

  localparam logic [2:0] REQ_TICK         = 3'd0;
  localparam logic [2:0] REQ_REMOTE_START = 3'd1;
  localparam logic [2:0] REQ_REMOTE_STOP  = 3'd2;
  localparam logic [2:0] REQ_LOCAL_START  = 3'd3;
  localparam logic [2:0] REQ_LOCAL_STOP   = 3'd4;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  localparam logic [1:0] ST_FAILED   = 2'd0;
  localparam logic [1:0] ST_ACKED    = 2'd1;
  localparam logic [1:0] ST_EXECUTED = 2'd2;

  localparam logic [1:0] RSN_NONE     = 2'd0;
  localparam logic [1:0] RSN_ACTIVE   = 2'd1;
  localparam logic [1:0] RSN_DURATION = 2'd2;

  localparam logic [15:0] TPS_RESET = 16'd1000;
  localparam int          MAX_REPORTS = 4;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [1:0]  reason;
    logic [30:0] id;
  } report_t;

  // one request's worth of results plus the state snapshot they all carry
  typedef struct packed {
    logic [2:0]            cnt;
    report_t [MAX_REPORTS-1:0] rep;
    logic                  valve_open;
    logic [30:0]           owner;
    logic [14:0]           dur_secs;
  } desc_t;

endpackage

>>> sv/tvc_front.sv
// Front end: accepts requests, runs the valve state and builds result descriptors.
module tvc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,
  input  logic [2:0]          in_tuser,
  input  logic                q_full,
  output logic                q_push,
  output tvc_pkg::desc_t      q_desc
);

  logic [15:0] tps_r;
  logic        on_r, on_nxt;
  logic [30:0] owner_r, owner_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [30:0] dticks_r, dticks_nxt;
  logic [14:0] secs_r, secs_nxt;

  logic [30:0] cid;
  logic [15:0] draw;
  logic        reach;
  logic        dur_ok;
  logic        accept;
  logic [31:0] el_inc;
  logic [30:0] prod;
  tvc_pkg::desc_t d;

  assign cid    = in_tdata[30:0];
  assign draw   = in_tdata[46:31];
  assign reach  = in_tdata[47];
  assign dur_ok = (draw != 16'd0) && !draw[15];
  assign prod   = 31'({16'd0, draw[14:0]} * {15'd0, tps_r});
  assign el_inc = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic [2:0] n;
    logic [30:0] was;
    n           = 3'd0;
    was         = owner_r;
    on_nxt      = on_r;
    owner_nxt   = owner_r;
    elapsed_nxt = elapsed_r;
    dticks_nxt  = dticks_r;
    secs_nxt    = secs_r;
    d           = '0;
    case (in_tuser)
      tvc_pkg::REQ_TICK: begin
        if (on_r) begin
          elapsed_nxt = el_inc;
          if (el_inc >= {1'b0, dticks_r}) begin
            on_nxt = 1'b0; owner_nxt = '0; elapsed_nxt = '0; dticks_nxt = '0; secs_nxt = '0;
            if (was != 31'd0) begin
              d.rep[n[1:0]] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, was};
              n = n + 3'd1;
              d.rep[n[1:0]] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, was};
              n = n + 3'd1;
            end else if (reach) begin
              d.rep[n[1:0]] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, 31'd0};
              n = n + 3'd1;
            end
          end
        end
      end
      tvc_pkg::REQ_REMOTE_START: begin
        if (on_r) begin
          d.rep[0] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_FAILED, tvc_pkg::RSN_ACTIVE, cid};
          n = 3'd1;
        end else if (!dur_ok) begin
          d.rep[0] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_FAILED, tvc_pkg::RSN_DURATION, cid};
          n = 3'd1;
        end else begin
          on_nxt = 1'b1; owner_nxt = cid; elapsed_nxt = '0;
          secs_nxt = draw[14:0]; dticks_nxt = prod;
          d.rep[0] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, 31'd0};
          d.rep[1] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_ACKED, tvc_pkg::RSN_NONE, cid};
          n = 3'd2;
        end
      end
      tvc_pkg::REQ_REMOTE_STOP: begin
        on_nxt = 1'b0; owner_nxt = '0; elapsed_nxt = '0; dticks_nxt = '0; secs_nxt = '0;
        if (was != 31'd0 && was != cid) begin
          d.rep[n[1:0]] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, was};
          n = n + 3'd1;
        end
        d.rep[n[1:0]] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_ACKED, tvc_pkg::RSN_NONE, cid};
        n = n + 3'd1;
        d.rep[n[1:0]] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, cid};
        n = n + 3'd1;
        d.rep[n[1:0]] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, cid};
        n = n + 3'd1;
      end
      tvc_pkg::REQ_LOCAL_START: begin
        if (!on_r && dur_ok) begin
          on_nxt = 1'b1; owner_nxt = '0; elapsed_nxt = '0;
          secs_nxt = draw[14:0]; dticks_nxt = prod;
          if (reach) begin
            d.rep[0] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, 31'd0};
            n = 3'd1;
          end
        end
      end
      tvc_pkg::REQ_LOCAL_STOP: begin
        if (on_r) begin
          on_nxt = 1'b0; owner_nxt = '0; elapsed_nxt = '0; dticks_nxt = '0; secs_nxt = '0;
          if (was != 31'd0) begin
            d.rep[0] = '{tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, was};
            d.rep[1] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, was};
            n = 3'd2;
          end else if (reach) begin
            d.rep[0] = '{tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, 31'd0};
            n = 3'd1;
          end
        end
      end
      default: begin
      end
    endcase
    d.cnt        = n;
    d.valve_open = on_nxt;
    d.owner      = owner_nxt;
    d.dur_secs   = secs_nxt;
  end

  assign q_push = accept && (d.cnt != 3'd0);
  assign q_desc = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= tvc_pkg::TPS_RESET;
      on_r      <= 1'b0;
      owner_r   <= '0;
      elapsed_r <= '0;
      dticks_r  <= '0;
      secs_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end
      if (accept) begin
        on_r      <= on_nxt;
        owner_r   <= owner_nxt;
        elapsed_r <= elapsed_nxt;
        dticks_r  <= dticks_nxt;
        secs_r    <= secs_nxt;
      end
    end
  end

endmodule

>>> sv/tvc_queue.sv
// Short descriptor queue between front and back ends.
module tvc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tvc_pkg::desc_t push_desc,
  input  logic           pop,
  output tvc_pkg::desc_t head_desc,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tvc_pkg::desc_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/tvc_back.sv
// Back end: walks each descriptor's reports out through the output register.
module tvc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tvc_pkg::desc_t head_desc,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [87:0]    out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);

  logic [1:0]       idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  tvc_pkg::report_t rep_r;
  logic             valve_r;
  logic [30:0]      owner_r;
  logic [14:0]      dur_r;
  logic             last_r;
  logic             load;
  logic             is_last;

  assign load    = !q_empty && (!valid_r || out_tready);
  assign is_last = ({1'b0, idx_r} == head_desc.cnt - 3'd1);
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rep_r   <= head_desc.rep[idx_r];
      valve_r <= head_desc.valve_open;
      owner_r <= head_desc.owner;
      dur_r   <= head_desc.dur_secs;
      last_r  <= is_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = rep_r.kind;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0, dur_r, owner_r, valve_r, rep_r.id, rep_r.reason, rep_r.status};

endmodule

>>> sv/timed_valve_command_controller.sv
// Top level of the timed valve command controller.
//
//  channel | direction | contents
//  in_     | request   | tuser req_type; tdata command_id, run_secs, server_reachable
//  out_    | result    | tuser report_kind; tdata ack/sync fields and state; tlast
//  cfg_    | write     | ticks_per_second
//
// A request is taken in the cycle it arrives while the descriptor queue has room.
// Each request yields 0 to 4 results, sent one per cycle from the output register while out_tready is high;
// the output stage sets the sustained rate at one result per cycle.
// Reset clears valve state, queue and output; ticks_per_second returns to 1000.
// A stalled output fills the queue, then in_tready drops.
`include "timed_valve_command_controller_defines.svh"

module timed_valve_command_controller #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // command_id[30:0], run_secs[46:31],
                                  // server_reachable[47]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // ack_status[1:0], failure_reason[3:2],
                                  // report_command_id[34:4], valve_open[35],
                                  // owner_command_id[66:36],
                                  // active_secs[81:67], zero pad
  output logic        out_tuser,  // report_kind
  output logic        out_tlast
);

  logic           q_full, q_empty, q_push, q_pop;
  tvc_pkg::desc_t push_desc, head_desc;
  logic           o_open;
  logic [14:0]    o_dur;
  logic [45:0]    o_tail;
  logic           o_fail;
  logic [1:0]     o_rsn;

  tvc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_desc      (push_desc)
  );

  tvc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .empty     (q_empty),
    .full      (q_full)
  );

  tvc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_desc  (head_desc),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign o_open = out_tdata[35];
  assign o_dur  = out_tdata[81:67];
  assign o_tail = out_tdata[81:36];
  assign o_fail = (out_tuser == tvc_pkg::KIND_ACK) && (out_tdata[1:0] == tvc_pkg::ST_FAILED);
  assign o_rsn  = out_tdata[3:2];

  `TVC_ASSERT_NOW(a_open_has_dur, out_tvalid && o_open, o_dur != 15'd0, "open valve, zero duration")
  `TVC_ASSERT_NOW(a_closed_clear, out_tvalid && !o_open, o_tail == 46'd0, "closed valve with state")
  `TVC_ASSERT_NOW(a_fail_reason, out_tvalid && o_fail, o_rsn != tvc_pkg::RSN_NONE, "failed, no reason")
  `TVC_ASSERT_NEXT(a_full_stalls, q_full && !q_pop, !in_tready, "request taken while queue full")

endmodule

>>> verif/timed_valve_command_controller_tb.sv
// Self-checking testbench for the timed valve command controller stream interface.
`timescale 1ns / 1ps

module timed_valve_command_controller_tb;

  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 60;
  localparam int PHASE_ITEMS   = 32;
  localparam int PHASE_TRIES   = 42;
  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_PHASES    = 5;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [1:0]  reason;
    logic [30:0] id;
    logic        valve;
    logic [30:0] owner;
    logic [14:0] dur;
    logic        last;
  } valve_report_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [30:0] id;
    logic [15:0] dur;
    logic        reach;
    logic        chk;
    logic [2:0]  e_cnt;
    logic [1:0]  e_status;
    logic [1:0]  e_reason;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  timed_valve_command_controller u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // predictor state
  logic        p_on;
  logic [30:0] p_owner;
  logic [31:0] p_elapsed;
  logic [31:0] p_dticks;
  logic [14:0] p_secs;
  logic [15:0] p_tps;

  tvc_pkg::report_t pending_reports[$];
  valve_report_t    item_reports[$];
  valve_report_t    expected_reports[$];

  int  errors;
  int  results_seen;
  int  cycle_count;
  int  rx_wait;
  bit  rx_hold;
  bit  no_idle;

  dir_row_t    dir_rows [NUM_DIRECTED];
  logic [15:0] tps_plan [NUM_PHASES];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  task automatic queue_report(logic kind, logic [1:0] status, logic [1:0] reason,
                              logic [30:0] id);
    tvc_pkg::report_t r;
    r.kind = kind;
    r.status = status;
    r.reason = reason;
    r.id = id;
    pending_reports.push_back(r);
  endtask

  task automatic go_idle();
    p_on = 1'b0;
    p_owner = '0;
    p_elapsed = '0;
    p_dticks = '0;
    p_secs = '0;
  endtask

  task automatic open_valve(logic [30:0] owner, logic [15:0] dur);
    p_on = 1'b1;
    p_owner = owner;
    p_elapsed = '0;
    p_secs = dur[14:0];
    p_dticks = {17'd0, p_secs} * {16'd0, p_tps};
  endtask

  // local stop or timeout
  task automatic close_valve(logic reach);
    logic [30:0] was;
    was = p_owner;
    go_idle();
    if (was != '0) begin
      queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, was);
      queue_report(tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, was);
    end else if (reach) begin
      queue_report(tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, '0);
    end
  endtask

  task automatic predict_request(input logic [2:0] req, input logic [30:0] cid,
                                 input logic [15:0] dur, input logic reach,
                                 output bit effect);
    logic        dur_ok;
    logic        was_on;
    logic [31:0] was_el;
    logic [30:0] prev;
    valve_report_t rec;
    was_on = p_on;
    was_el = p_elapsed;
    dur_ok = (dur != '0) && !dur[15];
    pending_reports.delete();
    item_reports.delete();
    case (req)
      tvc_pkg::REQ_TICK: begin
        if (p_on) begin
          if (p_elapsed != '1) p_elapsed++;
          if (p_elapsed >= p_dticks) close_valve(reach);
        end
      end
      tvc_pkg::REQ_REMOTE_START: begin
        if (p_on) begin
          queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_FAILED, tvc_pkg::RSN_ACTIVE, cid);
        end else if (!dur_ok) begin
          queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_FAILED, tvc_pkg::RSN_DURATION, cid);
        end else begin
          open_valve(cid, dur);
          queue_report(tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, '0);
          queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_ACKED, tvc_pkg::RSN_NONE, cid);
        end
      end
      tvc_pkg::REQ_REMOTE_STOP: begin
        prev = p_owner;
        go_idle();
        if (prev != '0 && prev != cid) begin
          queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, prev);
        end
        queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_ACKED, tvc_pkg::RSN_NONE, cid);
        queue_report(tvc_pkg::KIND_ACK, tvc_pkg::ST_EXECUTED, tvc_pkg::RSN_NONE, cid);
        queue_report(tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, cid);
      end
      tvc_pkg::REQ_LOCAL_START: begin
        if (!p_on && dur_ok) begin
          open_valve('0, dur);
          if (reach) queue_report(tvc_pkg::KIND_SYNC, tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE, '0);
        end
      end
      tvc_pkg::REQ_LOCAL_STOP: begin
        if (p_on) close_valve(reach);
      end
      default: ;
    endcase
    foreach (pending_reports[k]) begin
      rec.kind = pending_reports[k].kind;
      rec.status = pending_reports[k].status;
      rec.reason = pending_reports[k].reason;
      rec.id = pending_reports[k].id;
      rec.valve = p_on;
      rec.owner = p_on ? p_owner : '0;
      rec.dur = p_on ? p_secs : '0;
      rec.last = (k == pending_reports.size() - 1);
      item_reports.push_back(rec);
    end
    effect = (item_reports.size() != 0) || (was_on != p_on) || (was_el != p_elapsed);
  endtask

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_request(input logic [2:0] req, input logic [30:0] cid,
                              input logic [15:0] dur, input logic reach,
                              input logic chk, input logic [2:0] e_cnt,
                              input logic [1:0] e_status, input logic [1:0] e_reason,
                              output bit effect);
    int gap;
    valve_report_t rec;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = req;
    in_tdata = {reach, dur, cid};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_request(req, cid, dur, reach, effect);
    if (chk) begin
      // typed-in expectation replaces the predicted one
      item_reports.delete();
      if (e_cnt != 3'd0) begin
        rec.kind = tvc_pkg::KIND_ACK;
        rec.status = e_status;
        rec.reason = e_reason;
        rec.id = cid;
        rec.valve = p_on;
        rec.owner = p_on ? p_owner : '0;
        rec.dur = p_on ? p_secs : '0;
        rec.last = 1'b1;
        item_reports.push_back(rec);
      end
    end
    foreach (item_reports[k]) expected_reports.push_back(item_reports[k]);
    @(negedge clk);
  endtask

  task automatic random_request(output bit effect);
    int          r;
    logic [2:0]  req;
    logic [30:0] cid;
    logic [15:0] dur;
    r = $urandom_range(0, 99);
    if (r < 40)      req = tvc_pkg::REQ_TICK;
    else if (r < 55) req = tvc_pkg::REQ_REMOTE_START;
    else if (r < 65) req = tvc_pkg::REQ_REMOTE_STOP;
    else if (r < 78) req = tvc_pkg::REQ_LOCAL_START;
    else if (r < 92) req = tvc_pkg::REQ_LOCAL_STOP;
    else             req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    r = $urandom_range(0, 99);
    if (r < 30)      cid = p_owner;
    else if (r < 70) cid = 31'($urandom_range(0, 3));
    else             cid = 31'($urandom());
    r = $urandom_range(0, 99);
    if (r < 80)      dur = 16'($urandom_range(1, 4));
    else if (r < 90) dur = 16'($urandom());
    else begin
      case ($urandom_range(0, 3))
        0: dur = 16'h0000;
        1: dur = 16'h8000;
        2: dur = 16'h7FFF;
        default: dur = 16'hFFFF;
      endcase
    end
    send_request(req, cid, dur, 1'($urandom_range(0, 1)), 1'b0, 3'd0, tvc_pkg::ST_FAILED,
                 tvc_pkg::RSN_NONE, effect);
  endtask

  task automatic settle_and_configure(logic [15:0] value);
    in_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    p_tps = value;
  endtask

  // result side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready = 1'b0;
    end else begin
      out_tready = !rx_hold;
    end
  end

  always @(posedge clk) begin
    valve_report_t exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        errors++;
      end else begin
        exp_rec = expected_reports.pop_front();
        check_field("report_kind", 32'(exp_rec.kind), 32'(out_tuser));
        check_field("ack_status", 32'(exp_rec.status), 32'(out_tdata[1:0]));
        check_field("failure_reason", 32'(exp_rec.reason), 32'(out_tdata[3:2]));
        check_field("report_command_id", 32'(exp_rec.id), 32'(out_tdata[34:4]));
        check_field("valve_open", 32'(exp_rec.valve), 32'(out_tdata[35]));
        check_field("owner_command_id", 32'(exp_rec.owner), 32'(out_tdata[66:36]));
        check_field("active_secs", 32'(exp_rec.dur), 32'(out_tdata[81:67]));
        check_field("last", 32'(exp_rec.last), 32'(out_tlast));
      end
      rx_wait = draw_gap();
    end
  end

  // long receiver hold-off so the request queue fills and in_tready drops
  initial begin
    rx_hold = 1'b0;
    wait (results_seen >= HOLD_AFTER);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    bit effect;
    int done;
    int tries;
    errors = 0;
    results_seen = 0;
    cycle_count = 0;
    rx_wait = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    p_tps = tvc_pkg::TPS_RESET;
    go_idle();

    // req, id, dur, reach, chk, count; status, reason
    dir_rows[0]  = '{tvc_pkg::REQ_TICK, 31'd0, 16'd0, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[1]  = '{tvc_pkg::REQ_LOCAL_STOP, 31'd0, 16'd0, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[2]  = '{tvc_pkg::REQ_REMOTE_START, 31'd1, 16'd0, 1'b1, 1'b1, 3'd1,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_DURATION};
    dir_rows[3]  = '{tvc_pkg::REQ_REMOTE_START, 31'h7FFFFFFF, 16'h8000, 1'b0, 1'b1, 3'd1,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_DURATION};
    dir_rows[4]  = '{tvc_pkg::REQ_REMOTE_START, 31'd2, 16'hFFFF, 1'b1, 1'b1, 3'd1,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_DURATION};
    dir_rows[5]  = '{tvc_pkg::REQ_LOCAL_START, 31'd0, 16'd0, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[6]  = '{tvc_pkg::REQ_LOCAL_START, 31'd0, 16'h8000, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[7]  = '{tvc_pkg::REQ_REMOTE_STOP, 31'h7FFFFFFF, 16'd0, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[8]  = '{tvc_pkg::REQ_REMOTE_START, 31'h7FFFFFFF, 16'h7FFF, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[9]  = '{tvc_pkg::REQ_REMOTE_START, 31'd3, 16'd1, 1'b1, 1'b1, 3'd1,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_ACTIVE};
    dir_rows[10] = '{tvc_pkg::REQ_LOCAL_START, 31'd0, 16'd5, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[11] = '{tvc_pkg::REQ_TICK, 31'd0, 16'd0, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[12] = '{tvc_pkg::REQ_REMOTE_STOP, 31'd5, 16'd0, 1'b1, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[13] = '{tvc_pkg::REQ_LOCAL_START, 31'd0, 16'd1, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[14] = '{tvc_pkg::REQ_LOCAL_STOP, 31'd0, 16'd0, 1'b1, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[15] = '{tvc_pkg::REQ_LOCAL_START, 31'd0, 16'd1, 1'b1, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[16] = '{tvc_pkg::REQ_REMOTE_STOP, 31'd0, 16'd0, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[17] = '{tvc_pkg::REQ_REMOTE_START, 31'd0, 16'd1, 1'b1, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[18] = '{tvc_pkg::REQ_LOCAL_STOP, 31'd0, 16'd0, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[19] = '{tvc_pkg::REQ_REMOTE_START, 31'd77, 16'd1, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[20] = '{tvc_pkg::REQ_LOCAL_STOP, 31'd0, 16'd0, 1'b0, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[21] = '{tvc_pkg::REQ_REMOTE_START, 31'd9, 16'd2, 1'b1, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[22] = '{tvc_pkg::REQ_REMOTE_STOP, 31'd9, 16'd0, 1'b1, 1'b0, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[23] = '{REQ_UNKNOWN_LO, 31'h7FFFFFFF, 16'd1, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};
    dir_rows[24] = '{REQ_UNKNOWN_HI, 31'd0, 16'd1, 1'b1, 1'b1, 3'd0,
                     tvc_pkg::ST_FAILED, tvc_pkg::RSN_NONE};

    tps_plan[0] = 16'd1;
    tps_plan[1] = 16'd0;
    tps_plan[2] = 16'd2;
    tps_plan[3] = 16'hFFFF;
    tps_plan[4] = 16'd3;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].id, dir_rows[i].dur, dir_rows[i].reach,
                   dir_rows[i].chk, dir_rows[i].e_cnt, dir_rows[i].e_status,
                   dir_rows[i].e_reason, effect);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_and_configure(tps_plan[ph]);
      no_idle = (ph == 2);
      done = 0;
      tries = 0;
      while (done < PHASE_ITEMS && tries < PHASE_TRIES) begin
        random_request(effect);
        if (effect) done++;
        tries++;
      end
    end
    no_idle = 1'b0;

    in_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
